[rtl/fas_pkg.sv]
// Package for the frame animation sequencer: widths, codes, shared types and
// the frame stepping function. Used by every module of the block.
package fas_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int COUNT_W    = 7;
	localparam int TIME_W     = 32;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int S_DATA_W   = 72;
	localparam int M_DATA_W   = 8;

	localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLAMP    = 2'd2;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOPPED     = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_FRAMES);
	localparam logic [TIME_W-1:0]  TIME_SAT  = {TIME_W{1'b1}};

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [COUNT_W-1:0] count;
		logic               stopped;
	} fas_cfg_t;

	typedef struct packed {
		logic               cmd;
		logic [TIME_W-1:0]  elapsed;
		logic [FRAME_W-1:0] frame_index;
		logic [TIME_W-1:0]  duration;
	} fas_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] current_frame;
		logic               refreshed;
	} fas_result_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               fwd;
	} frame_step_t;

	function automatic frame_step_t next_frame(
		input logic [FRAME_W-1:0] cur,
		input logic               fwd,
		input logic [COUNT_W-1:0] count,
		input logic [MODE_W-1:0]  mode
	);
		frame_step_t        r;
		logic [COUNT_W-1:0] inc;
		logic               at_end;
		inc    = COUNT_W'(cur) + COUNT_W'(1);
		at_end = (inc >= count);
		r.frame = cur;
		r.fwd   = fwd;
		case (mode)
			MODE_LOOP: begin
				r.frame = at_end ? '0 : inc[FRAME_W-1:0];
			end
			MODE_PINGPONG: begin
				if (fwd) begin
					if (at_end) begin
						r.fwd   = 1'b0;
						r.frame = cur - FRAME_W'(1);
					end else begin
						r.frame = inc[FRAME_W-1:0];
					end
				end else if (cur == '0) begin
					r.fwd   = 1'b1;
					r.frame = FRAME_W'(1);
				end else begin
					r.frame = cur - FRAME_W'(1);
				end
			end
			MODE_CLAMP: begin
				r.frame = at_end ? FRAME_W'(count - COUNT_W'(1)) : inc[FRAME_W-1:0];
			end
			default: begin
				r.frame = cur;
			end
		endcase
		return r;
	endfunction

endpackage

[rtl/fas_dur_ram.sv]
// Frame duration table: one write port and one registered read port,
// write-first on an address collision. Depends on fas_pkg.
module fas_dur_ram
	import fas_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [FRAME_W-1:0] waddr,
	input  logic [TIME_W-1:0]  wdata,
	input  logic [FRAME_W-1:0] raddr,
	output logic [TIME_W-1:0]  rdata
);

	logic [TIME_W-1:0] mem [MAX_FRAMES];
	logic [TIME_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/fas_core.sv]
// Animation state and update: accumulator, frame and direction registers,
// with the duration table read ahead for the frame that comes next.
// Depends on fas_pkg and fas_dur_ram.
module fas_core
	import fas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  fas_cfg_t    cfg,
	input  logic        item_valid,
	input  fas_item_t   item,
	output fas_result_t result
);

	logic [FRAME_W-1:0] frame_q, frame_d;
	logic               fwd_q, fwd_d;
	logic [TIME_W-1:0]  accum_q, accum_d;
	logic [TIME_W-1:0]  cur_dur_q, cur_dur_d;
	logic [TIME_W-1:0]  nxt_dur;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  sat_sum;
	logic               is_write, is_tick, running, advance;
	frame_step_t        step_now, step_ahead;

	assign is_write = item_valid && (item.cmd == CMD_WRITE);
	assign is_tick  = item_valid && (item.cmd == CMD_TICK);
	assign running  = is_tick && !cfg.stopped && (cfg.count >= COUNT_W'(2));

	assign sum     = {1'b0, accum_q} + {1'b0, item.elapsed};
	assign sat_sum = sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];
	assign advance = running && (sat_sum >= cur_dur_q);

	assign step_now = next_frame(frame_q, fwd_q, cfg.count, cfg.mode);

	always_comb begin
		frame_d   = frame_q;
		fwd_d     = fwd_q;
		accum_d   = accum_q;
		cur_dur_d = cur_dur_q;
		if (running) begin
			accum_d = sat_sum;
		end
		if (advance) begin
			accum_d   = '0;
			frame_d   = step_now.frame;
			fwd_d     = step_now.fwd;
			cur_dur_d = nxt_dur;
		end
		if (is_write && (item.frame_index == frame_q)) begin
			cur_dur_d = item.duration;
		end
	end

	assign step_ahead = next_frame(frame_d, fwd_d, cfg.count, cfg.mode);

	fas_dur_ram u_ram (
		.clk   (clk),
		.we    (is_write),
		.waddr (item.frame_index),
		.wdata (item.duration),
		.raddr (step_ahead.frame),
		.rdata (nxt_dur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			fwd_q   <= 1'b1;
			accum_q <= '0;
		end else begin
			frame_q <= frame_d;
			fwd_q   <= fwd_d;
			accum_q <= accum_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_dur_q <= cur_dur_d;
	end

	assign result.current_frame = frame_d;
	assign result.refreshed     = running;

endmodule

[rtl/frame_animation_sequencer.sv]
// Top level of the frame animation sequencer: stream ports, configuration
// registers and the output register. Depends on fas_pkg and fas_core.
//
// Channel   Direction  Transfer when            Carries
// s_axis    in         s_tvalid && s_tready     one tick or one duration write
// m_axis    out        m_tvalid && m_tready     current frame and refresh flag
// cfg       in         cfg_valid && cfg_ready   register index and value
//
// One item per cycle while s_tready is high, and each result is registered.
// The duration of the next frame is read from the table ahead, so s_tready is
// low in the cycle after each configuration write. Reset clears the frame and
// accumulator and sets the direction forward; the table has no reset.
// A stalled output holds its result and s_tready follows m_tready.
module frame_animation_sequencer
	import fas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// elapsed [31:0], frame_index [37:32], duration [69:38], zeros [71:70]
	input  logic [S_DATA_W-1:0]   s_tdata,
	// cmd [0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// current_frame [5:0], zeros [7:6]
	output logic [M_DATA_W-1:0]   m_tdata,
	// refreshed [0]
	output logic                  m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [MODE_W-1:0]  mode_q;
	logic [COUNT_W-1:0] count_q;
	logic               stopped_q;
	logic               cfg_hold_q;
	logic               m_valid_q;
	fas_result_t        res_q;
	fas_result_t        result;
	fas_cfg_t           cfg;
	fas_item_t          item;
	logic               s_xfer, cfg_xfer;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign s_tready  = !cfg_hold_q && (!m_valid_q || m_tready);
	assign s_xfer    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_LOOP;
			count_q    <= '0;
			stopped_q  <= 1'b0;
			cfg_hold_q <= 1'b0;
		end else begin
			cfg_hold_q <= cfg_xfer;
			if (cfg_xfer) begin
				case (cfg_index)
					REG_PLAY_MODE:   mode_q    <= cfg_data[MODE_W-1:0];
					REG_FRAME_COUNT: count_q   <= cfg_data[COUNT_W-1:0];
					REG_STOPPED:     stopped_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg.mode    = mode_q;
	assign cfg.count   = (count_q > COUNT_MAX) ? COUNT_MAX : count_q;
	assign cfg.stopped = stopped_q;

	assign item.cmd         = s_tuser;
	assign item.elapsed     = s_tdata[TIME_W-1:0];
	assign item.frame_index = s_tdata[TIME_W+FRAME_W-1:TIME_W];
	assign item.duration    = s_tdata[2*TIME_W+FRAME_W-1:TIME_W+FRAME_W];

	fas_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (s_xfer),
		.item       (item),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_xfer) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			res_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_W-FRAME_W){1'b0}}, res_q.current_frame};
	assign m_tuser  = res_q.refreshed;

endmodule

[tb/fas_checker.sv]
// Checker for the frame animation sequencer: watches the input, output and register channels,
// tracks the animation state on its own and compares every output transfer against it.
// Depends on fas_pkg for field widths, codes and the item and result types.
module fas_checker
	import fas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_DATA_W-1:0]   m_tdata,
	input  logic                  m_tuser,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	logic [TIME_W-1:0]  dur_tab [MAX_FRAMES];
	logic [FRAME_W-1:0] frame_now = '0;
	logic [TIME_W-1:0]  accum     = '0;
	logic               fwd       = 1'b1;
	fas_cfg_t           cfg       = '0;
	fas_result_t        frames_due [$];
	fas_item_t          seen_item;
	fas_result_t        want;
	int                 fail_cnt = 0;

	function automatic fas_result_t step_animation(input fas_item_t it);
		fas_result_t        r;
		logic [COUNT_W-1:0] n;
		logic [TIME_W:0]    sum;
		logic               last;
		r.refreshed = 1'b0;
		if (it.cmd == CMD_WRITE) begin
			dur_tab[it.frame_index] = it.duration;
		end else begin
			n = (cfg.count > COUNT_MAX) ? COUNT_MAX : cfg.count;
			if (!cfg.stopped && n >= COUNT_W'(2)) begin
				sum   = {1'b0, accum} + {1'b0, it.elapsed};
				accum = sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];
				if (accum >= dur_tab[frame_now]) begin
					accum = '0;
					last  = (int'(frame_now) + 1 >= int'(n));
					case (cfg.mode)
						MODE_LOOP: begin
							frame_now = last ? '0 : frame_now + FRAME_W'(1);
						end
						MODE_PINGPONG: begin
							if (fwd) begin
								if (last) begin
									fwd       = 1'b0;
									frame_now = frame_now - FRAME_W'(1);
								end else begin
									frame_now = frame_now + FRAME_W'(1);
								end
							end else if (frame_now == '0) begin
								fwd       = 1'b1;
								frame_now = FRAME_W'(1);
							end else begin
								frame_now = frame_now - FRAME_W'(1);
							end
						end
						MODE_CLAMP: begin
							frame_now = last ? FRAME_W'(n - COUNT_W'(1)) : frame_now + FRAME_W'(1);
						end
						default: begin
						end
					endcase
				end
				r.refreshed = 1'b1;
			end
		end
		r.current_frame = frame_now;
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			frame_now = '0;
			accum     = '0;
			fwd       = 1'b1;
			cfg       = '0;
			frames_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (frames_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual frame %0d refreshed %0d",
						$time, m_tdata[FRAME_W-1:0], m_tuser);
					fail_cnt++;
				end else begin
					want = frames_due.pop_front();
					if (m_tdata[FRAME_W-1:0] !== want.current_frame) begin
						$display("%0t: current_frame expected %0d, actual %0d",
							$time, want.current_frame, m_tdata[FRAME_W-1:0]);
						fail_cnt++;
					end
					if (m_tuser !== want.refreshed) begin
						$display("%0t: refreshed expected %0d, actual %0d",
							$time, want.refreshed, m_tuser);
						fail_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PLAY_MODE:   cfg.mode    = cfg_data[MODE_W-1:0];
					REG_FRAME_COUNT: cfg.count   = cfg_data[COUNT_W-1:0];
					REG_STOPPED:     cfg.stopped = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				seen_item.cmd         = s_tuser;
				seen_item.elapsed     = s_tdata[TIME_W-1:0];
				seen_item.frame_index = s_tdata[TIME_W +: FRAME_W];
				seen_item.duration    = s_tdata[TIME_W+FRAME_W +: TIME_W];
				frames_due.push_back(step_animation(seen_item));
			end
		end
		mismatches  <= fail_cnt;
		outstanding <= frames_due.size();
	end

endmodule

[tb/testbench.sv]
// Top of the frame animation sequencer testbench: clock, reset, stimulus and the verdict.
// Depends on fas_pkg, the frame_animation_sequencer RTL and fas_checker.
module testbench;
	import fas_pkg::*;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	int                    mismatches;
	int                    outstanding;
	logic                  calm      = 1'b0;
	logic [MAX_FRAMES-1:0] written   = '0;
	int                    items_sent = 0;
	int                    sink_hold  = 0;

	frame_animation_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fas_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			m_tready  <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			m_tready  <= 1'b0;
			sink_hold <= $urandom_range(0, 7);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(input logic cmd, input logic [TIME_W-1:0] elapsed,
		input logic [FRAME_W-1:0] idx, input logic [TIME_W-1:0] dur);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, dur, idx, elapsed};
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (cmd == CMD_WRITE) written[idx] = 1'b1;
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic set_config(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count,
		input logic stop);
		cfg_valid <= 1'b1;
		cfg_index <= REG_PLAY_MODE;
		cfg_data  <= CFG_DATA_W'(mode);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_FRAME_COUNT;
		cfg_data  <= CFG_DATA_W'(count);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_STOPPED;
		cfg_data  <= CFG_DATA_W'(stop);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [TIME_W-1:0] pick_duration();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return TIME_SAT;
			2:       return $urandom;
			default: return $urandom_range(0, 'h30000);
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_elapsed();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return TIME_SAT;
			2, 3:    return $urandom;
			default: return $urandom_range(0, 'h18000);
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return COUNT_W'(1);
			2:       return COUNT_MAX;
			3:       return $urandom_range(0, 1) ? {COUNT_W{1'b1}} :
				COUNT_W'($urandom_range(65, 126));
			4:       return COUNT_W'(2);
			default: return COUNT_W'($urandom_range(3, 10));
		endcase
	endfunction

	// Every frame the animation can land on gets a duration before any tick runs.
	task automatic fill_durations(input logic [COUNT_W-1:0] count);
		int n;
		n = (count > COUNT_MAX) ? MAX_FRAMES : int'(count);
		for (int i = 0; i < n; i++) begin
			if (!written[i]) send_item(CMD_WRITE, $urandom, FRAME_W'(i), pick_duration());
		end
	endtask

	initial begin
		logic [COUNT_W-1:0] count;
		logic [MODE_W-1:0]  mode;
		int                 len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_TICK, TIME_SAT, {FRAME_W{1'b1}}, TIME_SAT);
		send_item(CMD_WRITE, '0, FRAME_W'(0), '0);
		send_item(CMD_WRITE, '0, FRAME_W'(1), TIME_SAT);
		send_item(CMD_WRITE, TIME_SAT, FRAME_W'(2), '0);
		send_item(CMD_WRITE, '0, {FRAME_W{1'b1}}, 32'hAAAA_5555);
		drain();
		set_config(MODE_LOOP, COUNT_W'(1), 1'b0);
		send_item(CMD_TICK, 32'h0001_0000, '0, '0);
		drain();
		set_config(MODE_LOOP, COUNT_W'(2), 1'b0);
		send_item(CMD_TICK, '0, '0, '0);
		send_item(CMD_TICK, 32'h8000_0000, '0, '0);
		send_item(CMD_TICK, 32'h9000_0000, '0, '0);
		send_item(CMD_TICK, '0, '0, '0);
		drain();
		set_config(MODE_LOOP, COUNT_W'(2), 1'b1);
		send_item(CMD_TICK, TIME_SAT, '0, '0);
		drain();
		set_config(MODE_PINGPONG, COUNT_W'(3), 1'b0);
		send_item(CMD_WRITE, '0, FRAME_W'(1), '0);
		repeat (4) send_item(CMD_TICK, '0, '0, '0);
		drain();
		set_config(MODE_W'(3), COUNT_W'(3), 1'b0);
		send_item(CMD_TICK, '0, '0, '0);
		drain();
		set_config(MODE_CLAMP, COUNT_W'(3), 1'b0);
		send_item(CMD_TICK, '0, '0, '0);
		send_item(CMD_TICK, '0, '0, '0);
		drain();
		set_config(MODE_PINGPONG, COUNT_W'(2), 1'b0);
		send_item(CMD_TICK, '0, '0, '0);

		while (items_sent < 650) begin
			drain();
			count = pick_count();
			mode  = ($urandom_range(0, 7) == 0) ? MODE_W'(3) : MODE_W'($urandom_range(0, 2));
			set_config(mode, count, $urandom_range(0, 7) == 0);
			fill_durations(count);
			len = $urandom_range(15, 50);
			repeat (len) begin
				if ($urandom_range(0, 7) == 0)
					send_item(CMD_WRITE, $urandom,
						FRAME_W'($urandom_range(0, MAX_FRAMES - 1)), pick_duration());
				else
					send_item(CMD_TICK, pick_elapsed(), FRAME_W'($urandom), $urandom);
			end
			if (items_sent > 560) calm <= 1'b1;
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/fas_pkg.sv
rtl/fas_dur_ram.sv
rtl/fas_core.sv
rtl/frame_animation_sequencer.sv
tb/fas_checker.sv
tb/testbench.sv
